// ===== hdl/plic_pkg.sv =====
// Package for the planar image layout calculator.
// Holds the request and result payload types, the pixel format codes and shared widths.
// No dependencies.
package plic_pkg;

    // Default upper limit applied to the requested width and height.
    localparam int unsigned DIM_MAX_DEF = 8191;

    // Field widths fixed by the interface.
    localparam int unsigned FMT_W  = 4;
    localparam int unsigned DIM_W  = 13;
    localparam int unsigned RDIM_W = 14;

    // Pixel format codes.
    localparam logic [FMT_W-1:0] FMT_RGB565 = 4'd0;
    localparam logic [FMT_W-1:0] FMT_RGB24  = 4'd1;
    localparam logic [FMT_W-1:0] FMT_RGB32  = 4'd2;
    localparam logic [FMT_W-1:0] FMT_I420   = 4'd3;
    localparam logic [FMT_W-1:0] FMT_S420   = 4'd4;
    localparam logic [FMT_W-1:0] FMT_YV12   = 4'd5;
    localparam logic [FMT_W-1:0] FMT_UYVY   = 4'd6;
    localparam logic [FMT_W-1:0] FMT_SUYV   = 4'd7;
    localparam logic [FMT_W-1:0] FMT_YUY2   = 4'd8;
    localparam logic [FMT_W-1:0] FMT_ST12   = 4'd9;
    localparam logic [FMT_W-1:0] FMT_SN12   = 4'd10;
    localparam logic [FMT_W-1:0] FMT_NV12   = 4'd11;

    // One layout request.
    typedef struct packed {
        logic [FMT_W-1:0] format_code;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } req_t;

    // One layout result.
    typedef struct packed {
        logic [RDIM_W-1:0] rounded_width;
        logic [RDIM_W-1:0] rounded_height;
        logic [15:0]       pitch_0;
        logic [13:0]       pitch_1;
        logic [12:0]       pitch_2;
        logic [26:0]       offset_1;
        logic [26:0]       offset_2;
        logic [28:0]       length_0;
        logic [24:0]       length_1;
        logic [24:0]       length_2;
        logic [28:0]       total_size;
        logic              unsupported;
    } res_t;

endpackage

// ===== hdl/plic_calc.sv =====
// Combinational layout calculation for one request.
// Two small multipliers (luma plane and chroma plane) followed by one add per output.
// Depends on plic_pkg.
module plic_calc #(
    parameter int unsigned DIM_MAX = plic_pkg::DIM_MAX_DEF
) (
    input  plic_pkg::req_t req,
    output plic_pkg::res_t res
);

    logic [12:0] w_sat;
    logic [12:0] h_sat;
    logic [13:0] w_even;
    logic [13:0] h_even;
    logic [13:0] h_eff;
    logic [13:0] p0_420;
    logic [12:0] p1_420;
    logic [15:0] p0_rgb24;
    logic        is_420;
    logic [15:0] mul_a_lhs;
    logic [13:0] mul_b_lhs;
    logic [29:0] prod_a;
    logic [26:0] prod_b;
    logic [28:0] add_rhs;
    logic [28:0] sum_total;
    logic [26:0] sum_offset_2;

    // Clamp the dimensions, then round them up to even.
    assign w_sat  = (32'(req.width) > DIM_MAX) ? 13'(DIM_MAX) : req.width;
    assign h_sat  = (32'(req.height) > DIM_MAX) ? 13'(DIM_MAX) : req.height;
    assign w_even = ({1'b0, w_sat} + 14'd1) & ~14'd1;
    assign h_even = ({1'b0, h_sat} + 14'd1) & ~14'd1;

    // The 4:2:0 planar formats use the even height and 4-byte aligned pitches.
    assign is_420 = (req.format_code == plic_pkg::FMT_I420) ||
                    (req.format_code == plic_pkg::FMT_S420) ||
                    (req.format_code == plic_pkg::FMT_YV12);
    assign h_eff    = is_420 ? h_even : {1'b0, h_sat};
    assign p0_420   = (w_even + 14'd3) & ~14'd3;
    assign p1_420   = (w_even[13:1] + 13'd3) & ~13'd3;
    assign p0_rgb24 = {1'b0, w_even, 1'b0} + {2'b00, w_even};

    // Select the first plane pitch and the chroma pitch that feed the multipliers.
    always_comb
    begin
        mul_a_lhs = '0;
        mul_b_lhs = '0;
        unique case (req.format_code)
            plic_pkg::FMT_RGB565:
            begin
                mul_a_lhs = {1'b0, w_even, 1'b0};
            end
            plic_pkg::FMT_RGB24:
            begin
                mul_a_lhs = p0_rgb24;
            end
            plic_pkg::FMT_RGB32:
            begin
                mul_a_lhs = {w_even, 2'b00};
            end
            plic_pkg::FMT_I420, plic_pkg::FMT_S420, plic_pkg::FMT_YV12:
            begin
                mul_a_lhs = {2'b00, p0_420};
                mul_b_lhs = {1'b0, p1_420};
            end
            plic_pkg::FMT_UYVY, plic_pkg::FMT_SUYV, plic_pkg::FMT_YUY2,
            plic_pkg::FMT_ST12, plic_pkg::FMT_SN12:
            begin
                mul_a_lhs = {1'b0, w_even, 1'b0};
            end
            plic_pkg::FMT_NV12:
            begin
                mul_a_lhs = {2'b00, w_even};
                mul_b_lhs = w_even;
            end
            default:
            begin
                mul_a_lhs = '0;
                mul_b_lhs = '0;
            end
        endcase
    end

    // Plane sizes: full height for the first plane, half height for chroma.
    assign prod_a = mul_a_lhs * h_eff;
    assign prod_b = mul_b_lhs * h_eff[13:1];

    // Planar 4:2:0 carries two chroma planes, NV12 one interleaved plane.
    assign add_rhs      = is_420 ? {1'b0, prod_b, 1'b0} : {2'b00, prod_b};
    assign sum_total    = prod_a[28:0] + add_rhs;
    assign sum_offset_2 = prod_a[26:0] + prod_b;

    // Assemble the result fields for each format family.
    always_comb
    begin
        res                = '0;
        res.rounded_width  = w_even;
        res.rounded_height = h_eff;
        unique case (req.format_code)
            plic_pkg::FMT_RGB565, plic_pkg::FMT_RGB24, plic_pkg::FMT_RGB32:
            begin
                res.pitch_0    = mul_a_lhs;
                res.length_0   = prod_a[28:0];
                res.total_size = prod_a[28:0];
            end
            plic_pkg::FMT_I420, plic_pkg::FMT_S420, plic_pkg::FMT_YV12:
            begin
                res.pitch_0    = mul_a_lhs;
                res.pitch_1    = {1'b0, p1_420};
                res.pitch_2    = p1_420;
                res.offset_1   = prod_a[26:0];
                res.offset_2   = sum_offset_2;
                res.length_0   = prod_a[28:0];
                res.length_1   = prod_b[24:0];
                res.length_2   = prod_b[24:0];
                res.total_size = sum_total;
            end
            plic_pkg::FMT_UYVY, plic_pkg::FMT_SUYV, plic_pkg::FMT_YUY2,
            plic_pkg::FMT_ST12, plic_pkg::FMT_SN12:
            begin
                res.pitch_0    = mul_a_lhs;
                res.total_size = prod_a[28:0];
            end
            plic_pkg::FMT_NV12:
            begin
                res.pitch_0    = mul_a_lhs;
                res.pitch_1    = w_even;
                res.offset_1   = prod_a[26:0];
                res.total_size = sum_total;
            end
            default:
            begin
                res.unsupported = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/planar_image_layout_calc.sv =====
// Planar image layout calculator, top level.
// Stages: the input register holds the accepted request, then the result register holds its layout.
// Throughput: one request per cycle while res_ready is held high; the calculation between the two registers is one
// multiply and one add per plane, and ready passes back through both stages.
// Reset: rst_n is asynchronous and active low; it empties both stages, payload is not cleared.
module planar_image_layout_calc #(
    parameter int unsigned DIM_MAX = plic_pkg::DIM_MAX_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  plic_pkg::req_t req_data,
    output logic           res_valid,
    input  logic           res_ready,
    output plic_pkg::res_t res_data
);

    logic           s1_valid_reg;
    logic           s1_valid_next;
    plic_pkg::req_t req_reg;
    logic           s2_valid_reg;
    logic           s2_valid_next;
    plic_pkg::res_t res_reg;
    plic_pkg::res_t calc_res;
    logic           s2_load;
    logic           s1_load;

    // Stage loads: the result register frees when empty or taken.
    assign s2_load   = !s2_valid_reg || res_ready;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign req_ready = s1_load;

    assign s1_valid_next = s1_load ? req_valid : s1_valid_reg;
    assign s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

    // Layout calculation on the registered request.
    plic_calc #(
        .DIM_MAX (DIM_MAX)
    ) u_calc (
        .req (req_reg),
        .res (calc_res)
    );

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            req_reg <= req_data;
        end
        if (s2_load)
        begin
            res_reg <= calc_res;
        end
    end

    assign res_valid = s2_valid_reg;
    assign res_data  = res_reg;

`ifndef SYNTHESIS
    // An accepted request always occupies the input stage in the next cycle.
    a_req_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> s1_valid_reg)
        else $error("accepted request did not enter the input stage");

    // A blocked input stage keeps its request.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_load |=> s1_valid_reg && $stable(req_reg))
        else $error("input stage lost its request while stalled");

    // Results always carry an even width.
    a_even_width: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res_data.rounded_width[0])
        else $error("rounded width is odd");

    // An unknown format produces no size.
    a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.unsupported |-> res_data.total_size == '0 &&
        res_data.pitch_0 == '0)
        else $error("unsupported format reported a size");
`endif

endmodule

// ===== tb/tb_planar_image_layout_calc.sv =====
// Self-checking testbench for planar_image_layout_calc: directed corner requests, then
// random requests with random idling on both handshakes, checked against a local predictor.
// Depends on plic_pkg and the planar_image_layout_calc RTL.
module tb_planar_image_layout_calc;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_REQUESTS = 1850;
    localparam int unsigned BURST_LEN       = 150;
    localparam int unsigned DRAIN_CYCLES    = 10;

    // Keeps the layouts still owed by the block and compares each result against the oldest.
    class layout_scoreboard;
        plic_pkg::res_t owed_layouts[$];
        int             mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Computes the image layout for one request.
        static function plic_pkg::res_t predict_layout(plic_pkg::req_t r);
            plic_pkg::res_t   lay;
            longint unsigned  w;
            longint unsigned  h;
            longint unsigned  chroma;
            lay = '0;
            w = 64'(r.width);
            h = 64'(r.height);
            if (w > plic_pkg::DIM_MAX_DEF)
            begin
                w = 64'(plic_pkg::DIM_MAX_DEF);
            end
            if (h > plic_pkg::DIM_MAX_DEF)
            begin
                h = 64'(plic_pkg::DIM_MAX_DEF);
            end
            w = (w + 1) & ~64'd1;
            case (r.format_code)
                plic_pkg::FMT_RGB565, plic_pkg::FMT_RGB24, plic_pkg::FMT_RGB32:
                begin
                    lay.pitch_0    = 16'(w * (r.format_code + 2));
                    lay.length_0   = 29'(w * (r.format_code + 2) * h);
                    lay.total_size = 29'(w * (r.format_code + 2) * h);
                end
                plic_pkg::FMT_I420, plic_pkg::FMT_S420, plic_pkg::FMT_YV12:
                begin
                    // Planar 4:2:0: even height, luma and chroma pitches aligned to 4 bytes.
                    h = (h + 1) & ~64'd1;
                    lay.pitch_0    = 16'((w + 3) & ~64'd3);
                    lay.length_0   = 29'(((w + 3) & ~64'd3) * h);
                    lay.offset_1   = 27'(((w + 3) & ~64'd3) * h);
                    lay.pitch_1    = 14'(((w >> 1) + 3) & ~64'd3);
                    lay.pitch_2    = 13'(((w >> 1) + 3) & ~64'd3);
                    chroma         = (((w >> 1) + 3) & ~64'd3) * (h >> 1);
                    lay.offset_2   = 27'(((w + 3) & ~64'd3) * h + chroma);
                    lay.length_1   = 25'(chroma);
                    lay.length_2   = 25'(chroma);
                    lay.total_size = 29'(((w + 3) & ~64'd3) * h + 2 * chroma);
                end
                plic_pkg::FMT_UYVY, plic_pkg::FMT_SUYV, plic_pkg::FMT_YUY2,
                plic_pkg::FMT_ST12, plic_pkg::FMT_SN12:
                begin
                    lay.pitch_0    = 16'(w << 1);
                    lay.total_size = 29'((w << 1) * h);
                end
                plic_pkg::FMT_NV12:
                begin
                    // Full-width interleaved chroma plane of half height.
                    lay.pitch_0    = 16'(w);
                    lay.pitch_1    = 14'(w);
                    lay.offset_1   = 27'(w * h);
                    lay.total_size = 29'(w * h + w * (h >> 1));
                end
                default:
                begin
                    lay.unsupported = 1'b1;
                end
            endcase
            lay.rounded_width  = 14'(w);
            lay.rounded_height = 14'(h);
            return lay;
        endfunction

        function void note_request(plic_pkg::req_t r);
            owed_layouts.push_back(predict_layout(r));
        endfunction

        function int owed_count();
            return owed_layouts.size();
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            end
        endfunction

        function void check_result(plic_pkg::res_t got);
            plic_pkg::res_t want;
            if (owed_layouts.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
                return;
            end
            want = owed_layouts.pop_front();
            compare_field("rounded_width",  64'(want.rounded_width),  64'(got.rounded_width));
            compare_field("rounded_height", 64'(want.rounded_height), 64'(got.rounded_height));
            compare_field("pitch_0",        64'(want.pitch_0),        64'(got.pitch_0));
            compare_field("pitch_1",        64'(want.pitch_1),        64'(got.pitch_1));
            compare_field("pitch_2",        64'(want.pitch_2),        64'(got.pitch_2));
            compare_field("offset_1",       64'(want.offset_1),       64'(got.offset_1));
            compare_field("offset_2",       64'(want.offset_2),       64'(got.offset_2));
            compare_field("length_0",       64'(want.length_0),       64'(got.length_0));
            compare_field("length_1",       64'(want.length_1),       64'(got.length_1));
            compare_field("length_2",       64'(want.length_2),       64'(got.length_2));
            compare_field("total_size",     64'(want.total_size),     64'(got.total_size));
            compare_field("unsupported",    64'(want.unsupported),    64'(got.unsupported));
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    plic_pkg::req_t req_data;
    logic           res_valid;
    logic           res_ready;
    plic_pkg::res_t res_data;

    // When set, neither side idles.
    bit calm;

    layout_scoreboard layouts = new();

    planar_image_layout_calc u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Known input values from time zero, then a single reset pulse.
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        res_ready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    function int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Sends one request after an idle gap and returns at the edge that accepts it.
    task automatic send_request(input plic_pkg::req_t r);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (!req_ready);
        layouts.note_request(r);
    endtask

    task automatic send_fields(input logic [plic_pkg::FMT_W-1:0] fmt, input int unsigned w,
                               input int unsigned h);
        plic_pkg::req_t r;
        r.format_code = fmt;
        r.width       = 13'(w);
        r.height      = 13'(h);
        send_request(r);
    endtask

    // Holds the sender until every owed result has come back.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (layouts.owed_count() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function logic [plic_pkg::DIM_W-1:0] random_dim();
        int unsigned pick;
        int unsigned corners [6] = '{0, 1, 4095, 4096, 8190, 8191};
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            return 13'($urandom_range(0, 32));
        end
        else if (pick < 8)
        begin
            return 13'($urandom_range(0, 8191));
        end
        return 13'(corners[$urandom_range(0, 5)]);
    endfunction

    // Result side: random stalls, then checks each accepted result.
    initial
    begin
        int unsigned gap;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
            layouts.check_result(res_data);
        end
    end

    // Request side: directed corners, then random requests.
    initial
    begin
        plic_pkg::req_t r;
        int             wait_cycles;
        calm = 1'b0;
        @(posedge rst_n);
        @(posedge clk);

        // Every format code, including the unknown ones, at the largest size.
        for (int f = 0; f < 16; f++)
        begin
            send_fields(4'(f), plic_pkg::DIM_MAX_DEF, plic_pkg::DIM_MAX_DEF);
        end
        // Zero, odd and smallest sizes across the plane layouts.
        send_fields(plic_pkg::FMT_I420,   1,    1);
        send_fields(plic_pkg::FMT_YV12,   0,    0);
        send_fields(plic_pkg::FMT_NV12,   3,    5);
        send_fields(plic_pkg::FMT_RGB24,  8190, 1);
        send_fields(plic_pkg::FMT_S420,   8189, 8190);
        send_fields(plic_pkg::FMT_UYVY,   0,    8191);
        send_fields(plic_pkg::FMT_RGB565, 1,    0);
        send_fields(plic_pkg::FMT_SN12,   4097, 3);
        wait_for_drain();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // Alternate stretches with and without idling.
            calm = ((n / BURST_LEN) % 3) == 1;
            if (n == RANDOM_REQUESTS / 2)
            begin
                wait_for_drain();
            end
            if ($urandom_range(0, 99) < 85)
            begin
                r.format_code = 4'($urandom_range(plic_pkg::FMT_RGB565, plic_pkg::FMT_NV12));
            end
            else
            begin
                r.format_code = 4'($urandom_range(plic_pkg::FMT_NV12 + 1, 15));
            end
            r.width  = random_dim();
            r.height = random_dim();
            send_request(r);
        end
        req_valid <= 1'b0;

        // Let every owed result come back, then a few spare cycles.
        wait_cycles = 0;
        while (layouts.owed_count() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (layouts.owed_count() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0", $realtime,
                     layouts.owed_count());
            layouts.mismatches++;
        end

        if (layouts.mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
